// ----- rtl/core/complex_magnitude_sum_top_defines.svh -----
// Assertion macros shared by the complex magnitude sum block.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef COMPLEX_MAGNITUDE_SUM_TOP_DEFINES_SVH
`define COMPLEX_MAGNITUDE_SUM_TOP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define CMS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define CMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/cms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cms_pkg;

  localparam int SAMPLE_W = 32;
  localparam int ROOT_W   = 32;
  localparam int RAD_W    = 64;
  localparam int REM_W    = 33;
  localparam int SHIFT_W  = 35;
  localparam int DIFF_W   = 36;
  localparam int SUM_W    = 64;

  // One request travelling down the square root chain.
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } cms_cell_t;

endpackage

`default_nettype wire

// ----- rtl/core/cms_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cms_front
  import cms_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       sample_valid,
  input  logic signed [SAMPLE_W-1:0] real_part,
  input  logic signed [SAMPLE_W-1:0] imag_part,
  input  logic                       last_element,
  output cms_cell_t                  head
);

  logic                  abs_valid;
  logic                  abs_last;
  logic [SAMPLE_W-1:0]   abs_re;
  logic [SAMPLE_W-1:0]   abs_im;
  logic                  sq_valid;
  logic                  sq_last;
  logic [2*SAMPLE_W-1:0] sq_re;
  logic [2*SAMPLE_W-1:0] sq_im;
  logic                  en_valid;
  logic                  en_last;
  logic [RAD_W-1:0]      energy;

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_valid <= 1'b0;
      sq_valid  <= 1'b0;
      en_valid  <= 1'b0;
    end else if (advance) begin
      abs_valid <= sample_valid;
      sq_valid  <= abs_valid;
      en_valid  <= sq_valid;
    end
  end

  // The magnitude of the most negative part, 2^31, still fits as unsigned.
  always_ff @(posedge clk) begin
    if (advance) begin
      abs_last <= last_element;
      abs_re   <= real_part[SAMPLE_W-1] ? (~real_part + 1'b1) : real_part;
      abs_im   <= imag_part[SAMPLE_W-1] ? (~imag_part + 1'b1) : imag_part;
      sq_last  <= abs_last;
      sq_re    <= {{SAMPLE_W{1'b0}}, abs_re} * {{SAMPLE_W{1'b0}}, abs_re};
      sq_im    <= {{SAMPLE_W{1'b0}}, abs_im} * {{SAMPLE_W{1'b0}}, abs_im};
      en_last  <= sq_last;
      energy   <= sq_re + sq_im;
    end
  end

  assign head.valid = en_valid;
  assign head.last  = en_last;
  assign head.rem   = '0;
  assign head.root  = '0;
  assign head.rad   = energy;

endmodule

`default_nettype wire

// ----- rtl/core/cms_sqrt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cms_sqrt_cell
  import cms_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  cms_cell_t cell_in,
  output cms_cell_t cell_out
);

  logic [SHIFT_W-1:0] shifted;
  logic [DIFF_W-1:0]  diff;
  logic               take;
  cms_cell_t          cell_next;

  // One restoring square root step: bring down two radicand bits and try
  // subtracting 4*root + 1.
  always_comb begin
    shifted = {cell_in.rem, cell_in.rad[RAD_W-1 -: 2]};
    diff    = {1'b0, shifted} - {{(DIFF_W-ROOT_W-2){1'b0}}, cell_in.root, 2'b01};
    take    = ~diff[DIFF_W-1];
    cell_next.valid = cell_in.valid;
    cell_next.last  = cell_in.last;
    cell_next.rem   = take ? diff[REM_W-1:0] : shifted[REM_W-1:0];
    cell_next.root  = {cell_in.root[ROOT_W-2:0], take};
    cell_next.rad   = {cell_in.rad[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (advance) begin
      cell_out <= cell_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/complex_magnitude_sum_top.sv -----
// Pipeline: an accepted sample that is the last element reaches the output
// through 3 front stages, 32 square root cells and 1 accumulate stage.
// Throughput: one sample per cycle; the whole pipeline advances together and
// freezes only while a finished sum waits in the output register under stall.
// Reset (rst, synchronous): clears all valid bits, the output valid and the
// running sum; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

`include "complex_magnitude_sum_top_defines.svh"

module complex_magnitude_sum_top
  import cms_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  logic signed [SAMPLE_W-1:0] real_part,
  input  logic signed [SAMPLE_W-1:0] imag_part,
  input  logic                       last_element,
  output logic                       sum_valid,
  input  logic                       sum_stall,
  output logic [SUM_W-1:0]           magnitude_sum
);

  // The pipeline moves whenever the output register is empty or is being
  // taken in this cycle.
  logic             advance;
  cms_cell_t        chain [0:ROOT_W];
  cms_cell_t        tail;
  logic [SUM_W-1:0] running_sum;
  logic [SUM_W-1:0] total;

  assign advance      = ~(sum_valid & sum_stall);
  assign sample_stall = ~advance;

  // Absolute values, squares and the energy sum.
  cms_front u_front (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .sample_valid (sample_valid),
    .real_part    (real_part),
    .imag_part    (imag_part),
    .last_element (last_element),
    .head         (chain[0])
  );

  // The integer square root is a row of identical cells, each resolving one
  // root bit from two radicand bits and handing the request to its neighbor.
  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    cms_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  assign tail  = chain[ROOT_W];
  assign total = running_sum + {{(SUM_W-ROOT_W){1'b0}}, tail.root};

  // The accumulator wraps modulo 2^64. A last element hands the sum,
  // including its own magnitude, to the output register and clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      sum_valid   <= 1'b0;
    end else if (advance) begin
      sum_valid <= tail.valid & tail.last;
      if (tail.valid) begin
        running_sum <= tail.last ? '0 : total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tail.valid && tail.last) begin
      magnitude_sum <= total;
    end
  end

  `CMS_ASSERT_NEXT(a_clear_after_last, advance && tail.valid && tail.last, running_sum == '0)
  `CMS_ASSERT_NEXT(a_last_gives_sum, advance && tail.valid && tail.last, sum_valid)
  `CMS_ASSERT_NEXT(a_freeze_holds_sum, sum_valid && sum_stall, $stable(running_sum))
  `CMS_ASSERT_SAME(a_root_bounded, tail.valid, tail.rem <= {tail.root, 1'b0})

endmodule

`default_nettype wire
